@@ rtl/tsp_pkg.sv @@
// Package for the transmit slot pool: sizes, status codes, controller states,
// the command and status bundles between controller and datapath.
// No dependencies; used by every module of the block.
package tsp_pkg;

    localparam int SLOT_COUNT    = 10;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
    localparam int TIME_W        = 48;
    localparam int LIMIT_W       = 24;
    localparam int MASK_W        = SLOT_COUNT;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 56;
    localparam int OUT_DATA_W    = 16;
    localparam logic [LIMIT_W-1:0] STALE_RESET_US = LIMIT_W'(2 * 1000 * 1000);

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_RELEASED     = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_RETRY,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_step;
        logic retry;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic grab_ok;
        logic sweep_done;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_free;

    // Lowest free slot of the busy mask.
    function automatic t_free first_free(input logic [SLOT_COUNT-1:0] busy);
        t_free res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                res.found = 1'b1;
                res.idx   = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/tsp_ctrl.sv @@
// Controller state machine of the transmit slot pool.
// Depends on tsp_pkg; drives commands into tsp_dpath and reads its status.
module tsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  tsp_pkg::t_stat i_stat,
    output tsp_pkg::t_cmd  o_cmd
);

    tsp_pkg::t_state r_state;
    tsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsp_pkg::S_IDLE: begin
                if (i_req_valid) n_state = tsp_pkg::S_EXEC;
            end
            tsp_pkg::S_EXEC: begin
                if (i_stat.is_release || i_stat.grab_ok) n_state = tsp_pkg::S_RESULT;
                else n_state = tsp_pkg::S_SWEEP;
            end
            tsp_pkg::S_SWEEP: begin
                if (i_stat.sweep_done) n_state = tsp_pkg::S_RETRY;
            end
            tsp_pkg::S_RETRY: begin
                n_state = tsp_pkg::S_RESULT;
            end
            tsp_pkg::S_RESULT: begin
                if (i_stat.out_free) n_state = tsp_pkg::S_IDLE;
            end
            default: begin
                n_state = tsp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            tsp_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            tsp_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            tsp_pkg::S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            tsp_pkg::S_RETRY: begin
                o_cmd.retry = 1'b1;
            end
            tsp_pkg::S_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/tsp_dpath.sv @@
// Datapath of the transmit slot pool: request capture, busy mask, claim time
// memory, stale sweep with age compare, result and output registers.
// Depends on tsp_pkg; sequenced by tsp_ctrl.
module tsp_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsp_pkg::t_cmd                   i_cmd,
    output tsp_pkg::t_stat                  o_stat,
    input  logic                            i_func,
    input  logic [tsp_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [tsp_pkg::TIME_W-1:0]      i_now_us,
    input  logic                            i_cfg_we,
    input  logic [tsp_pkg::LIMIT_W-1:0]     i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tsp_pkg::STATUS_W-1:0]    o_status,
    output logic [tsp_pkg::IDX_W-1:0]       o_granted_slot,
    output logic [tsp_pkg::MASK_W-1:0]      o_reclaimed_mask
);

    logic                              r_func;
    logic [tsp_pkg::IDX_W-1:0]         r_slot;
    logic [tsp_pkg::TIME_W-1:0]        r_now;
    logic [tsp_pkg::LIMIT_W-1:0]       r_limit;
    logic [tsp_pkg::SLOT_COUNT-1:0]    r_busy;
    logic [tsp_pkg::SLOT_COUNT-1:0]    n_busy;
    logic [tsp_pkg::TIME_W-1:0]        r_claim_time [tsp_pkg::SLOT_COUNT];
    logic [tsp_pkg::TIME_W-1:0]        r_rd_data;
    logic [tsp_pkg::CNT_W-1:0]         r_idx;
    logic                              r_cmp_vld;
    logic [tsp_pkg::IDX_W-1:0]         r_cmp_idx;
    tsp_pkg::t_status                  r_status;
    tsp_pkg::t_status                  n_status;
    logic [tsp_pkg::IDX_W-1:0]         r_granted;
    logic [tsp_pkg::IDX_W-1:0]         n_granted;
    logic [tsp_pkg::MASK_W-1:0]        r_recl;
    logic                              r_out_vld;
    tsp_pkg::t_status                  r_out_status;
    logic [tsp_pkg::IDX_W-1:0]         r_out_granted;
    logic [tsp_pkg::MASK_W-1:0]        r_out_recl;

    tsp_pkg::t_free                    free;
    logic                              grab;
    logic                              slot_ok;
    logic                              rd_en;
    logic [tsp_pkg::TIME_W-1:0]        age;
    logic                              stale;

    assign free    = tsp_pkg::first_free(r_busy);
    assign grab    = (i_cmd.exec && !r_func) || i_cmd.retry;
    assign slot_ok = ({1'b0, r_slot} < (tsp_pkg::IDX_W + 1)'(tsp_pkg::SLOT_COUNT));
    assign rd_en   = i_cmd.sweep_step && (r_idx != tsp_pkg::CNT_W'(tsp_pkg::SLOT_COUNT));

    // The age wraps with the 48-bit time stamp.
    assign age   = r_now - r_rd_data;
    assign stale = r_cmp_vld && r_busy[r_cmp_idx] &&
                   (age > {{(tsp_pkg::TIME_W - tsp_pkg::LIMIT_W){1'b0}}, r_limit});

    assign o_stat.is_release = r_func;
    assign o_stat.grab_ok    = free.found;
    assign o_stat.sweep_done = (r_idx == tsp_pkg::CNT_W'(tsp_pkg::SLOT_COUNT)) && !r_cmp_vld;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        n_busy    = r_busy;
        n_status  = r_status;
        n_granted = r_granted;
        if (i_cmd.exec && r_func) begin
            n_granted = '0;
            if (slot_ok) begin
                n_busy[r_slot] = 1'b0;
                n_status       = tsp_pkg::ST_RELEASED;
            end else begin
                n_status = tsp_pkg::ST_OUT_OF_RANGE;
            end
        end else if (grab) begin
            if (free.found) begin
                n_busy[free.idx] = 1'b1;
                n_status         = tsp_pkg::ST_GRANTED;
                n_granted        = free.idx;
            end else begin
                n_status  = tsp_pkg::ST_EXHAUSTED;
                n_granted = '0;
            end
        end else if (stale) begin
            n_busy[r_cmp_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= tsp_pkg::STALE_RESET_US;
            r_busy    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_busy <= n_busy;
            if (i_cmd.exec) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                // One slot is read while the previous one is compared.
                r_cmp_vld <= rd_en;
                if (rd_en) r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.out_load) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_slot <= i_slot_index;
            r_now  <= i_now_us;
        end
        r_status  <= n_status;
        r_granted <= n_granted;
        if (i_cmd.exec) r_recl <= '0;
        else if (stale) r_recl[r_cmp_idx] <= 1'b1;
        if (rd_en) r_cmp_idx <= r_idx[tsp_pkg::IDX_W-1:0];
        if (i_cmd.out_load) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_recl    <= r_recl;
        end
    end

    // Claim time memory: written on a grant, read one slot a cycle in a sweep.
    always_ff @(posedge i_clk) begin
        if (grab && free.found) r_claim_time[free.idx] <= r_now;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_claim_time[r_idx[tsp_pkg::IDX_W-1:0]];
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out_status;
    assign o_granted_slot   = r_out_granted;
    assign o_reclaimed_mask = r_out_recl;

endmodule

@@ rtl/tx_slot_pool_with_stale_reclaim_core.sv @@
// Top level of the transmit slot pool with stale reclaim.
// Claim or release, no sweep: S_IDLE loads, S_EXEC executes, S_RESULT registers the result.
// Claim on a full pool: S_SWEEP reads the one-read-port claim time memory, then S_RETRY.
// One request in flight: a new one is taken only after S_RESULT, also while a result waits.
// Synchronous active-low reset frees all slots and loads the stale limit with 2000000 us.
// Depends on tsp_pkg, tsp_ctrl and tsp_dpath.
module tx_slot_pool_with_stale_reclaim_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tsp_pkg::IN_DATA_W-1:0]      s_tdata,  // slot_index[3:0], now_us[51:4], zero
    input  logic                               s_tuser,  // func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tsp_pkg::OUT_DATA_W-1:0]     m_tdata,  // granted_slot[3:0], reclaimed_mask[13:4]
    output logic [tsp_pkg::STATUS_W-1:0]       m_tuser,  // status
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tsp_pkg::LIMIT_W-1:0]        i_cfg_data
);

    tsp_pkg::t_cmd                   cmd;
    tsp_pkg::t_stat                  stat;
    logic [tsp_pkg::IDX_W-1:0]       granted_slot;
    logic [tsp_pkg::MASK_W-1:0]      reclaimed_mask;

    assign o_cfg_ready = 1'b1;

    tsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tsp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (s_tuser),
        .i_slot_index     (s_tdata[tsp_pkg::IDX_W-1:0]),
        .i_now_us         (s_tdata[tsp_pkg::IDX_W +: tsp_pkg::TIME_W]),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (m_tvalid),
        .i_out_ready      (m_tready),
        .o_status         (m_tuser),
        .o_granted_slot   (granted_slot),
        .o_reclaimed_mask (reclaimed_mask)
    );

    assign m_tdata = {{(tsp_pkg::OUT_DATA_W - tsp_pkg::IDX_W - tsp_pkg::MASK_W){1'b0}},
                      reclaimed_mask, granted_slot};

endmodule

@@ rtl/tsp_checker.sv @@
// Port-level checker for the transmit slot pool, bound to the top level.
// Depends on tsp_pkg and tx_slot_pool_with_stale_reclaim_core.
module tsp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [tsp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [tsp_pkg::STATUS_W-1:0]       m_tuser
);

    // Only one request is in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_granted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != tsp_pkg::ST_GRANTED) |-> m_tdata[tsp_pkg::IDX_W-1:0] == '0)
        else $error("granted slot nonzero without a grant");

    a_release_no_reclaim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == tsp_pkg::ST_RELEASED || m_tuser == tsp_pkg::ST_OUT_OF_RANGE)
        |-> m_tdata[tsp_pkg::IDX_W +: tsp_pkg::MASK_W] == '0)
        else $error("release reports reclaimed slots");

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind tx_slot_pool_with_stale_reclaim_core tsp_checker u_tsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the transmit slot pool: a table of directed requests, then random
// claim and release traffic under several stale limits, checked against a predictor.
// Depends on tsp_pkg and tx_slot_pool_with_stale_reclaim_core.
module tb;

    localparam logic FN_CLAIM    = 1'b0;
    localparam logic FN_RELEASE  = 1'b1;
    localparam int   DIR_ROWS    = 16;
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 165;
    localparam int   STALL_LIMIT = 2000;
    localparam int   DRAIN_CYCLES = 20;

    typedef struct packed {
        tsp_pkg::t_status                   status;
        logic [tsp_pkg::IDX_W-1:0]          slot;
        logic [tsp_pkg::MASK_W-1:0]         reclaimed;
    } t_slot_reply;

    typedef struct packed {
        logic                               func;
        logic [tsp_pkg::IDX_W-1:0]          idx;
        logic [tsp_pkg::TIME_W-1:0]         now;
        logic [3:0]                         reps;
        logic                               typed;
        t_slot_reply                        want;
    } t_stim_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [tsp_pkg::IN_DATA_W-1:0]      s_tdata;   // slot_index[3:0], now_us[51:4], zero
    logic                               s_tuser;   // func
    logic                               m_tvalid;
    logic                               m_tready;
    logic [tsp_pkg::OUT_DATA_W-1:0]     m_tdata;   // granted_slot[3:0], reclaimed_mask[13:4]
    logic [tsp_pkg::STATUS_W-1:0]       m_tuser;   // status
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [tsp_pkg::LIMIT_W-1:0]        i_cfg_data;

    // Predictor state.
    logic [tsp_pkg::SLOT_COUNT-1:0]     pool_busy;
    logic [tsp_pkg::TIME_W-1:0]         pool_stamp [tsp_pkg::SLOT_COUNT];
    logic [tsp_pkg::LIMIT_W-1:0]        stale_limit;

    t_slot_reply pending_replies [$];
    t_slot_reply seen_reply;
    t_slot_reply due_reply;
    t_stim_row   dir_rows [DIR_ROWS];
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          tx_idle_pct = 23;
    int          rx_idle_pct = 56;

    always #5 i_clk = ~i_clk;

    tx_slot_pool_with_stale_reclaim_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int grab_slot(input logic [tsp_pkg::TIME_W-1:0] now);
        for (int i = 0; i < tsp_pkg::SLOT_COUNT; i++) begin
            if (!pool_busy[i]) begin
                pool_busy[i]  = 1'b1;
                pool_stamp[i] = now;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_slot_reply predict_reply(input logic func,
                                                  input logic [tsp_pkg::IDX_W-1:0] idx,
                                                  input logic [tsp_pkg::TIME_W-1:0] now);
        t_slot_reply                    r;
        int                             got;
        logic [tsp_pkg::TIME_W-1:0]     age;
        r.status    = tsp_pkg::ST_GRANTED;
        r.slot      = '0;
        r.reclaimed = '0;
        if (func == FN_RELEASE) begin
            if (idx < tsp_pkg::SLOT_COUNT) begin
                pool_busy[idx] = 1'b0;
                r.status = tsp_pkg::ST_RELEASED;
            end else begin
                r.status = tsp_pkg::ST_OUT_OF_RANGE;
            end
        end else begin
            got = grab_slot(now);
            if (got < 0) begin
                // Full pool: free every slot older than the limit, then try again.
                for (int i = 0; i < tsp_pkg::SLOT_COUNT; i++) begin
                    age = now - pool_stamp[i];
                    if (pool_busy[i] && age > tsp_pkg::TIME_W'(stale_limit)) begin
                        pool_busy[i]   = 1'b0;
                        r.reclaimed[i] = 1'b1;
                    end
                end
                got = grab_slot(now);
            end
            if (got >= 0) begin
                r.slot = tsp_pkg::IDX_W'(got);
            end else begin
                r.status = tsp_pkg::ST_EXHAUSTED;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic func, input logic [tsp_pkg::IDX_W-1:0] idx,
                                input logic [tsp_pkg::TIME_W-1:0] now, input logic typed,
                                input t_slot_reply want);
        t_slot_reply r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, now, idx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        r = predict_reply(func, idx, now);
        pending_replies.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [tsp_pkg::LIMIT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stale_limit = value;
    endtask

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_reply.status    = tsp_pkg::t_status'(m_tuser);
            seen_reply.slot      = m_tdata[3:0];
            seen_reply.reclaimed = m_tdata[13:4];
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d mask %h",
                         $time, seen_reply.status, seen_reply.slot, seen_reply.reclaimed);
                fail_count++;
            end else begin
                due_reply = pending_replies.pop_front();
                if (seen_reply.status != due_reply.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             due_reply.status, seen_reply.status);
                    fail_count++;
                end
                if (seen_reply.slot != due_reply.slot) begin
                    $display("%0t: granted_slot expected %0d actual %0d", $time,
                             due_reply.slot, seen_reply.slot);
                    fail_count++;
                end
                if (seen_reply.reclaimed != due_reply.reclaimed) begin
                    $display("%0t: reclaimed_mask expected %h actual %h", $time,
                             due_reply.reclaimed, seen_reply.reclaimed);
                    fail_count++;
                end
            end
        end
    end

    // Any handshake counts as progress; a long quiet stretch means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [tsp_pkg::LIMIT_W-1:0] phase_limit [PHASES];
        logic [tsp_pkg::TIME_W-1:0]  wall_us;
        logic [tsp_pkg::TIME_W-1:0]  now;
        logic                        func;
        logic [tsp_pkg::IDX_W-1:0]   idx;
        int                          roll;

        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        m_tready    <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        pool_busy   = '0;
        stale_limit = tsp_pkg::STALE_RESET_US;
        for (int i = 0; i < tsp_pkg::SLOT_COUNT; i++) pool_stamp[i] = '0;

        dir_rows[0]  = '{FN_CLAIM,   4'd0,  48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_GRANTED, 4'd0, 10'd0}};
        dir_rows[1]  = '{FN_CLAIM,   4'd0,  48'd1, 4'd1, 1'b1,
                         '{tsp_pkg::ST_GRANTED, 4'd1, 10'd0}};
        dir_rows[2]  = '{FN_RELEASE, 4'd15, 48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_OUT_OF_RANGE, 4'd0, 10'd0}};
        dir_rows[3]  = '{FN_RELEASE, 4'd10, 48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_OUT_OF_RANGE, 4'd0, 10'd0}};
        dir_rows[4]  = '{FN_RELEASE, 4'd1,  48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_RELEASED, 4'd0, 10'd0}};
        // Releasing a slot that is already free still answers released.
        dir_rows[5]  = '{FN_RELEASE, 4'd1,  48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_RELEASED, 4'd0, 10'd0}};
        dir_rows[6]  = '{FN_CLAIM,   4'd0,  48'd2, 4'd1, 1'b1,
                         '{tsp_pkg::ST_GRANTED, 4'd1, 10'd0}};
        dir_rows[7]  = '{FN_CLAIM,   4'd0,  48'd100, 4'd8, 1'b0, '0};
        // Only slot 0 is past the limit: it is reclaimed and granted again.
        dir_rows[8]  = '{FN_CLAIM,   4'd0,  48'd2000001, 4'd1, 1'b0, '0};
        // Slot 1 sits exactly at the limit, which is not stale: pool exhausted.
        dir_rows[9]  = '{FN_CLAIM,   4'd0,  48'd2000002, 4'd1, 1'b0, '0};
        dir_rows[10] = '{FN_CLAIM,   4'd0,  48'hFFFF_FFFF_FFFF, 4'd1, 1'b0, '0};
        dir_rows[11] = '{FN_CLAIM,   4'd0,  48'hFFFF_FFFF_FFF0, 4'd9, 1'b0, '0};
        // The time stamp wrapped, so every age is small and nothing is stale.
        dir_rows[12] = '{FN_CLAIM,   4'd0,  48'd5, 4'd1, 1'b0, '0};
        dir_rows[13] = '{FN_RELEASE, 4'd9,  48'hFFFF_FFFF_FFFF, 4'd1, 1'b1,
                         '{tsp_pkg::ST_RELEASED, 4'd0, 10'd0}};
        dir_rows[14] = '{FN_CLAIM,   4'd15, 48'd0, 4'd1, 1'b0, '0};
        dir_rows[15] = '{FN_RELEASE, 4'd0,  48'd0, 4'd1, 1'b1,
                         '{tsp_pkg::ST_RELEASED, 4'd0, 10'd0}};

        phase_limit[0] = '0;
        phase_limit[1] = '1;
        phase_limit[2] = tsp_pkg::LIMIT_W'($urandom);
        phase_limit[3] = tsp_pkg::LIMIT_W'(1);
        phase_limit[4] = tsp_pkg::LIMIT_W'($urandom_range(0, 100000));
        phase_limit[5] = tsp_pkg::STALE_RESET_US;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                send_request(dir_rows[r].func, dir_rows[r].idx, dir_rows[r].now,
                             dir_rows[r].typed, dir_rows[r].want);
            end
        end

        wall_us = 48'd0;
        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct = (ph / 2 == 0) ? 23 : (ph / 2 == 1) ? 56 : 0;
            rx_idle_pct = (ph / 2 == 0) ? 56 : (ph / 2 == 1) ? 23 : 0;
            s_tvalid <= 1'b0;
            wait_drained();
            write_limit(phase_limit[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    // Hold off new requests until the block has answered all of them.
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    func = FN_CLAIM;
                    idx  = tsp_pkg::IDX_W'($urandom);
                end else if (roll < 92) begin
                    func = FN_RELEASE;
                    idx  = tsp_pkg::IDX_W'($urandom_range(0, tsp_pkg::SLOT_COUNT - 1));
                end else begin
                    func = FN_RELEASE;
                    idx  = tsp_pkg::IDX_W'($urandom_range(tsp_pkg::SLOT_COUNT, 15));
                end
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    wall_us = tsp_pkg::TIME_W'({$urandom, $urandom});
                end else if (roll < 7) begin
                    wall_us = '1 - tsp_pkg::TIME_W'($urandom_range(0, stale_limit));
                end else begin
                    wall_us = wall_us
                              + tsp_pkg::TIME_W'($urandom_range(0, stale_limit / 4 + 3));
                end
                now = (roll > 96) ? tsp_pkg::TIME_W'({$urandom, $urandom}) : wall_us;
                send_request(func, idx, now, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tsp_pkg.sv
rtl/tsp_ctrl.sv
rtl/tsp_dpath.sv
rtl/tx_slot_pool_with_stale_reclaim_core.sv
rtl/tsp_checker.sv
tb/sv/tb.sv
